// File: sv/csn_pkg.sv
// Shared constants and types for the contrast-stretch normalizer.
package csn_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 1'd1;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  typedef struct packed {
    logic scan;
    logic capture;
    logic mul;
    logic div_step;
    logic out_load;
  } csn_cmd_t;

endpackage

// File: sv/csn_if.sv
// Valid/ready stream interfaces for the sample and result channels.
interface csn_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic                      restart;
  logic [csn_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output mode, output restart, output pixel, input ready);
  modport sink (input valid, input mode, input restart, input pixel, output ready);
endinterface

interface csn_result_if;
  logic                      valid;
  logic                      ready;
  logic [csn_pkg::PIX_W-1:0] mapped;

  modport source (output valid, output mapped, input ready);
  modport sink (input valid, input mapped, output ready);
endinterface

// File: sv/csn_datapath.sv
// Datapath: statistics, range registers, multiplier, serial divider, result register.
module csn_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  csn_pkg::csn_cmd_t             cmd,
  input  logic                          restart,
  input  logic [csn_pkg::PIX_W-1:0]     pixel,
  input  logic                          cfg_wr_en,
  input  logic [csn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csn_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic [csn_pkg::PIX_W-1:0]     mapped
);

  localparam int W = csn_pkg::PIX_W;

  logic [W-1:0]   seen_min;
  logic [W-1:0]   seen_max;
  logic [W-1:0]   out_low;
  logic [W-1:0]   out_high;

  logic [W-1:0]   pix;
  logic           clamp_low;
  logic           clamp_high;
  logic           neg;
  logic [W-1:0]   den;
  logic [W-1:0]   rem;
  logic [W-1:0]   dq;

  logic [W-1:0]   min_base;
  logic [W-1:0]   max_base;
  logic [W:0]     span;
  logic [W-1:0]   span_mag;
  logic [W-1:0]   diff;
  logic [2*W-1:0] prod;
  logic [W:0]     shifted;
  logic           fits;
  logic [W-1:0]   quot_signed;
  logic [W-1:0]   result;

  assign min_base = restart ? csn_pkg::PIX_MAX : seen_min;
  assign max_base = restart ? csn_pkg::PIX_MIN : seen_max;

  assign span     = {1'b0, out_high} - {1'b0, out_low};
  assign span_mag = span[W] ? W'(-span) : span[W-1:0];
  assign diff     = pix - seen_min;
  assign prod     = {{W{1'b0}}, span_mag} * {{W{1'b0}}, diff};

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign shifted = {rem, dq[W-1]};
  assign fits    = shifted >= {1'b0, den};

  assign quot_signed = neg ? (out_low - dq) : (out_low + dq);
  assign result = clamp_low ? out_low : (clamp_high ? out_high : quot_signed);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_min <= csn_pkg::PIX_MAX;
      seen_max <= csn_pkg::PIX_MIN;
      out_low  <= csn_pkg::PIX_MIN;
      out_high <= csn_pkg::PIX_MAX;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          csn_pkg::REG_OUT_LOW:  out_low  <= cfg_data[W-1:0];
          csn_pkg::REG_OUT_HIGH: out_high <= cfg_data[W-1:0];
          default: ;
        endcase
      end
      if (cmd.scan) begin
        seen_min <= (pixel < min_base) ? pixel : min_base;
        seen_max <= (pixel > max_base) ? pixel : max_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix        <= pixel;
      clamp_low  <= pixel < seen_min;
      clamp_high <= pixel >= seen_max;
    end
    if (cmd.mul) begin
      neg <= span[W];
      den <= seen_max - seen_min;
      rem <= prod[2*W-1:W];
      dq  <= prod[W-1:0];
    end
    if (cmd.div_step) begin
      rem <= fits ? W'(shifted - {1'b0, den}) : shifted[W-1:0];
      dq  <= {dq[W-2:0], fits};
    end
    if (cmd.out_load) begin
      mapped <= result;
    end
  end

endmodule

// File: sv/csn_ctrl.sv
// Controller: takes scan items and sequences one map item through multiply, divide and result load.
module csn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output csn_pkg::csn_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                     state;
  logic [csn_pkg::CNT_W-1:0]  cnt;
  logic                       in_xfer;
  logic                       out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.scan     = in_xfer && (in_mode == csn_pkg::MODE_SCAN);
    cmd.capture  = in_xfer && (in_mode == csn_pkg::MODE_MAP);
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.out_load = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == csn_pkg::CNT_W'(csn_pkg::DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_map_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_MUL))
    else $error("map transfer did not start the multiply step");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && (cnt == csn_pkg::CNT_W'(csn_pkg::DIV_STEPS - 1)) |=> (state == ST_DONE))
    else $error("divider did not finish after its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded over a pending result");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_valid && !out_ready |=> (state == ST_DONE))
    else $error("finished result dropped while output stalled");

  a_scan_single: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |=> in_ready)
    else $error("scan transfer left the block busy");

endmodule

// File: sv/contrast_stretch_normalizer_core.sv
// Top level of the contrast-stretch normalizer: controller plus datapath.
//
// The image streams through twice. A scan transfer (mode 0) folds its pixel
// into the running minimum and maximum at its transfer and gives no result;
// restart clears the statistics first. A map transfer (mode 1) gives one
// mapped value: out_low below the minimum, out_high at or above the maximum,
// otherwise out_low + (out_high - out_low) * (pixel - min) / (max - min),
// truncated toward zero. On a map transfer the edge captures the pixel and
// its clamp flags; then the 8x8 multiply is registered, the bit-serial
// restoring divider forms one quotient bit per cycle, and the result is
// loaded into the result register once it is free. The next item can be
// taken in the cycle after the load. The block takes one item at a time;
// while it is idle, a scan item can follow every cycle. A finished result
// waits in the output register while the next item is taken, and a following
// map item holds in its last step until that register frees. out_low and
// out_high are written through the cfg port (index 0 and 1); the user must
// write them only while no map item is in flight, as the block does not check.
module contrast_stretch_normalizer_core (
  input  logic                          clk,
  input  logic                          rst,
  csn_sample_if.sink                    sample,
  csn_result_if.source                  result,
  input  logic                          cfg_wr_en,
  input  logic [csn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csn_pkg::CFG_DAT_W-1:0] cfg_data
);

  csn_pkg::csn_cmd_t cmd;

  // Sequence the handshakes and issue one command set per cycle.
  csn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_mode   (sample.mode),
    .out_ready (result.ready),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  // Hold statistics and range, compute and register the mapped value.
  csn_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .restart   (sample.restart),
    .pixel     (sample.pixel),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mapped    (result.mapped)
  );

endmodule

// File: tb/contrast_stretch_normalizer_core_test.sv
// Self-checking testbench for the contrast-stretch normalizer core.
`timescale 1ns / 1ps

module contrast_stretch_normalizer_core_test;
  import csn_pkg::*;

  // Sample items after the directed table; no new round starts once this many have gone in.
  localparam int RAND_ITEMS   = 1800;
  // Idle cycles before a register write, after the last result has arrived.
  // This covers the map pipeline with margin.
  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES  = 20;
  // Cycles without any transfer or register write before the run is called hung.
  localparam int HANG_LIMIT   = 1000;
  localparam int SHOW_LIMIT   = 10;
  // A table row with this value takes its expectation from the predictor.
  localparam int WANT_PREDICT = -1;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_COIN, RX_CHOKE} rx_style_e;

  // For a register row, value is the data and reg_idx the register.
  // For a sample row, value is the pixel.
  typedef struct {
    row_kind_e              kind;
    logic                   mode;
    logic                   restart;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [PIX_W-1:0]       value;
    int                     want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  csn_sample_if sample_ch ();
  csn_result_if result_ch ();

  contrast_stretch_normalizer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: output levels and running statistics, at reset values.
  logic [PIX_W-1:0] lvl_low  = PIX_MIN;
  logic [PIX_W-1:0] lvl_high = PIX_MAX;
  logic [PIX_W-1:0] stat_min = PIX_MAX;
  logic [PIX_W-1:0] stat_max = PIX_MIN;

  // Mapped values still owed by the block, oldest first.
  logic [PIX_W-1:0] mapped_q [$];

  int        error_count  = 0;
  int        result_count = 0;
  int        sample_count = 0;
  int        burst_left   = 0;
  int        hang_count   = 0;
  int        stall_left   = 0;
  rx_style_e stall_style  = RX_OPEN;
  logic [PIX_W-1:0] want_val;

  // Directed table: empty statistics after reset, out-of-range pixels on both
  // sides, the exact minimum and maximum, restart on a map transfer (ignored),
  // an inverted output range, full-range statistics, and a single-sample image.
  row_t plan [26] = '{
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd0,   0},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd254, 0},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd255, 255},
    '{ROW_SAMPLE, MODE_SCAN, 1'b1, REG_OUT_LOW,  8'd100, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_SCAN, 1'b0, REG_OUT_LOW,  8'd50,  WANT_PREDICT},
    '{ROW_SAMPLE, MODE_SCAN, 1'b0, REG_OUT_LOW,  8'd200, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd49,  0},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd50,  WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd125, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd199, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd200, 255},
    '{ROW_SAMPLE, MODE_MAP,  1'b1, REG_OUT_LOW,  8'd255, 255},
    '{ROW_CFG,    MODE_SCAN, 1'b0, REG_OUT_LOW,  8'd255, WANT_PREDICT},
    '{ROW_CFG,    MODE_SCAN, 1'b0, REG_OUT_HIGH, 8'd0,   WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd49,  255},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd125, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd200, 0},
    '{ROW_SAMPLE, MODE_SCAN, 1'b1, REG_OUT_LOW,  8'd0,   WANT_PREDICT},
    '{ROW_SAMPLE, MODE_SCAN, 1'b0, REG_OUT_LOW,  8'd255, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd0,   WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd254, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_SCAN, 1'b1, REG_OUT_LOW,  8'd128, WANT_PREDICT},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd127, 255},
    '{ROW_SAMPLE, MODE_MAP,  1'b0, REG_OUT_LOW,  8'd128, 0},
    '{ROW_CFG,    MODE_SCAN, 1'b0, REG_OUT_LOW,  8'd0,   WANT_PREDICT},
    '{ROW_CFG,    MODE_SCAN, 1'b0, REG_OUT_HIGH, 8'd255, WANT_PREDICT}
  };

  // Linear stretch of one pixel from [stat_min, stat_max] onto [lvl_low, lvl_high].
  // SystemVerilog int division truncates toward zero, which an inverted range needs.
  function automatic logic [PIX_W-1:0] stretch_pixel(input logic [PIX_W-1:0] p);
    int span;
    int num;
    int den;
    if (p < stat_min) return lvl_low;
    if (p >= stat_max) return lvl_high;
    span = int'(lvl_high) - int'(lvl_low);
    num  = span * (int'(p) - int'(stat_min));
    den  = int'(stat_max) - int'(stat_min);
    return PIX_W'(int'(lvl_low) + num / den);
  endfunction

  // Present one sample and hold it until the block takes it. Called at a rising
  // edge; returns at the edge of the transfer, or after an idle gap between bursts.
  // Without a gap, valid stays high on return so that the next item of a burst follows at once.
  task automatic push_sample(input logic m, input logic r, input logic [PIX_W-1:0] p,
                             input int want);
    int gap;
    sample_ch.valid   <= 1'b1;
    sample_ch.mode    <= m;
    sample_ch.restart <= r;
    sample_ch.pixel   <= p;
    do @(posedge clk); while (!sample_ch.ready);
    sample_count++;
    if (m == MODE_SCAN) begin
      // Restart clears the statistics before this pixel folds in.
      if (r) begin
        stat_min = PIX_MAX;
        stat_max = PIX_MIN;
      end
      if (p < stat_min) stat_min = p;
      if (p > stat_max) stat_max = p;
    end else if (want >= 0) begin
      mapped_q.push_back(PIX_W'(want));
    end else begin
      mapped_q.push_back(stretch_pixel(p));
    end
    // End the burst with a random gap, sometimes none at all.
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Write one output level once the block has gone quiet.
  task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
    sample_ch.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_OUT_LOW) lvl_low = val;
    else lvl_high = val;
  endtask

  // Stimulus: reset, directed table, then random images.
  initial begin
    int                rand_start;
    int                n;
    int                lo_b;
    int                hi_b;
    int                pick;
    logic              m;
    logic              r;
    logic [PIX_W-1:0]  p;
    logic [PIX_W-1:0]  new_low;
    logic [PIX_W-1:0]  new_high;

    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_OUT_LOW;
    cfg_data          <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.mode    <= MODE_SCAN;
    sample_ch.restart <= 1'b0;
    sample_ch.pixel   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_level(plan[i].reg_idx, plan[i].value);
      else push_sample(plan[i].mode, plan[i].restart, plan[i].value, plan[i].want);
    end

    // Random part: each round scans an image, then maps it, the way the block
    // is meant to be used. A few stray items of the wrong kind are mixed in.
    rand_start = sample_count;
    while (sample_count - rand_start < RAND_ITEMS) begin
      // Change the output levels now and then, extremes included.
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: begin
            new_low  = PIX_MIN;
            new_high = PIX_MAX;
          end
          1: begin
            new_low  = PIX_MAX;
            new_high = PIX_MIN;
          end
          2: begin
            new_low  = PIX_W'($urandom_range(0, 255));
            new_high = new_low;
          end
          default: begin
            new_low  = PIX_W'($urandom_range(0, 255));
            new_high = PIX_W'($urandom_range(0, 255));
          end
        endcase
        write_level(REG_OUT_LOW, new_low);
        write_level(REG_OUT_HIGH, new_high);
      end

      // Pick the image size and brightness band; mostly small, rarely large.
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0) begin
        lo_b = 0;
        hi_b = 255;
      end else begin
        lo_b = $urandom_range(0, 255);
        hi_b = $urandom_range(lo_b, 255);
      end

      // Scan pass; usually open with restart, sometimes keep the old statistics.
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          m = 1'($urandom_range(0, 1));
          r = 1'($urandom_range(0, 1));
          p = PIX_W'($urandom_range(0, 255));
        end else begin
          m = MODE_SCAN;
          r = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
          p = PIX_W'($urandom_range(lo_b, hi_b));
        end
        push_sample(m, r, p, WANT_PREDICT);
      end

      // Map pass: mostly inside the band, with its edges and outliers.
      n = $urandom_range(1, 2 * n);
      for (int k = 0; k < n; k++) begin
        m    = MODE_MAP;
        r    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 7);
        case (pick)
          0: p = PIX_W'($urandom_range(0, 255));
          1: p = PIX_W'(lo_b - 1);
          2: p = PIX_W'(lo_b);
          3: p = PIX_W'(hi_b);
          4: p = PIX_W'(hi_b + 1);
          default: p = PIX_W'($urandom_range(lo_b, hi_b));
        endcase
        // A stray scan in the middle of the map pass moves the statistics.
        if ($urandom_range(0, 31) == 0) m = MODE_SCAN;
        push_sample(m, r, p, WANT_PREDICT);
      end
    end

    // Drain: wait for every owed result, then a short tail for strays.
    sample_ch.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && mapped_q.size() == 0)
      $display("[contrast_stretch_normalizer_core] OK");
    else
      $display("[contrast_stretch_normalizer_core] ERROR");
    $finish;
  end

  // Receiver: switch among stall styles, holding each for a random stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= rx_style_e'($urandom_range(0, 3));
      stall_left  <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      case (stall_style)
        RX_OPEN:  result_ch.ready <= 1'b1;
        RX_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_COIN:  result_ch.ready <= 1'($urandom_range(0, 1));
        default:  result_ch.ready <= (stall_left[3:0] == 4'd0);
      endcase
    end
  end

  // Checker: compare every result transfer with the oldest owed value.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      result_count++;
      if (mapped_q.size() == 0) begin
        error_count++;
        if (error_count <= SHOW_LIMIT)
          $display("result %0d: none expected, got mapped=%0d", result_count,
                   result_ch.mapped);
      end else begin
        want_val = mapped_q.pop_front();
        if (result_ch.mapped !== want_val) begin
          error_count++;
          if (error_count <= SHOW_LIMIT)
            $display("result %0d: mapped expected %0d, got %0d", result_count,
                     want_val, result_ch.mapped);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        cfg_wr_en) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("[contrast_stretch_normalizer_core] ERROR");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

endmodule
